[rtl/zcfm_pkg.sv]
package zcfm_pkg;

  localparam int DEPTH      = 64;
  localparam int PTR_W      = $clog2(DEPTH);
  localparam int FILL_W     = PTR_W + 1;
  localparam int SAMPLE_W   = 12;
  localparam int SUM_W      = SAMPLE_W + PTR_W;
  localparam int PROD_W     = SAMPLE_W + FILL_W;
  localparam int RATE_W     = 20;
  localparam int FRAC_W     = 8;
  localparam int FREQ_W     = 27;
  localparam int DIVIDEND_W = RATE_W + FRAC_W;
  localparam int CNT_W      = FILL_W;
  localparam int STEP_W     = $clog2(DIVIDEND_W + 1);
  localparam int CHG_W      = 2;

  localparam logic [FILL_W-1:0] MIN_FILL   = FILL_W'(3);
  localparam logic [CHG_W-1:0]  CROSSINGS  = CHG_W'(3);
  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(1000);

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic read_old;
    logic push;
    logic setup;
    logic walk;
    logic div_start;
    logic div_run;
    logic load_out;
  } zcfm_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic few;
    logic found;
    logic walk_end;
    logic div_done;
    logic out_busy;
  } zcfm_status_t;

endpackage

[rtl/zero_crossing_frequency_meter.sv]
// Channel  | Handshake              | Payload
// ---------+------------------------+------------------------------------
// input    | in_valid / in_ready    | adc_sample[11:0]
// output   | out_valid / out_ready  | freq_valid, freq_q8_hz[26:0]
// config   | cfg_wr_en              | sample_rate_hz[19:0]
//
// One beat in, one beat out; in_ready is high only in IDLE, so a new sample is not
// taken until the last result has been loaded into the output register. Fewer than 3
// held samples skip the walk; otherwise the walk runs until a third crossing is found
// or the held samples run out: the walk reads one stored sample per cycle from the single
// read port of the ring, and the restoring divider resolves one quotient bit per
// cycle. Synchronous active-high reset clears pointer, fill count, sum, rate (1000).
// A result waiting in the output register stalls only the final load.
module zero_crossing_frequency_meter (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [zcfm_pkg::SAMPLE_W-1:0] adc_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          freq_valid,
  output logic [zcfm_pkg::FREQ_W-1:0]   freq_q8_hz,
  input  logic                          cfg_wr_en,
  input  logic [zcfm_pkg::RATE_W-1:0]   sample_rate_hz
);

  zcfm_pkg::zcfm_cmd_t    cmd;
  zcfm_pkg::zcfm_status_t st;

  // Sequence push, walk, divide and result load
  zcfm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // Ring store, running sum, crossing counter, divider, output register
  zcfm_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .st             (st),
    .adc_sample     (adc_sample),
    .cfg_wr_en      (cfg_wr_en),
    .sample_rate_hz (sample_rate_hz),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .freq_valid     (freq_valid),
    .freq_q8_hz     (freq_q8_hz)
  );

endmodule

[rtl/zcfm_ctrl.sv]
module zcfm_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  zcfm_pkg::zcfm_status_t st,
  output zcfm_pkg::zcfm_cmd_t    cmd
);

  typedef enum logic [2:0] {
    IDLE,
    READ_OLD,
    PUSH,
    SETUP,
    WALK,
    DIV_INIT,
    DIV_RUN,
    FINISH
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = 1'b0;
    case (state)
      IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = READ_OLD;
        end
      end
      READ_OLD: begin
        cmd.read_old = 1'b1;
        state_next   = PUSH;
      end
      PUSH: begin
        cmd.push   = 1'b1;
        state_next = SETUP;
      end
      SETUP: begin
        cmd.setup  = 1'b1;
        state_next = st.few ? FINISH : WALK;
      end
      WALK: begin
        cmd.walk = 1'b1;
        if (st.found) begin
          state_next = DIV_INIT;
        end else if (st.walk_end) begin
          state_next = FINISH;
        end
      end
      DIV_INIT: begin
        cmd.div_start = 1'b1;
        state_next    = DIV_RUN;
      end
      DIV_RUN: begin
        cmd.div_run = 1'b1;
        if (st.div_done) begin
          state_next = FINISH;
        end
      end
      FINISH: begin
        if (!st.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[rtl/zcfm_dp.sv]
module zcfm_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  zcfm_pkg::zcfm_cmd_t                 cmd,
  output zcfm_pkg::zcfm_status_t              st,
  input  logic [zcfm_pkg::SAMPLE_W-1:0]       adc_sample,
  input  logic                                cfg_wr_en,
  input  logic [zcfm_pkg::RATE_W-1:0]         sample_rate_hz,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                freq_valid,
  output logic [zcfm_pkg::FREQ_W-1:0]         freq_q8_hz
);

  logic [zcfm_pkg::SAMPLE_W-1:0]   mem [zcfm_pkg::DEPTH];
  logic [zcfm_pkg::SAMPLE_W-1:0]   rdata;

  logic [zcfm_pkg::RATE_W-1:0]     rate;
  logic [zcfm_pkg::SAMPLE_W-1:0]   sample;
  logic [zcfm_pkg::PTR_W-1:0]      wp;
  logic [zcfm_pkg::FILL_W-1:0]     fill;
  logic [zcfm_pkg::SUM_W-1:0]      sum;

  logic [zcfm_pkg::PTR_W-1:0]      addr;
  logic [zcfm_pkg::FILL_W-1:0]     remain;
  logic                            rd_pend;
  logic                            side;
  logic [zcfm_pkg::CHG_W-1:0]      changes;
  logic [zcfm_pkg::CNT_W-1:0]      count;
  logic                            found;

  logic [zcfm_pkg::CNT_W-1:0]      divisor;
  logic [zcfm_pkg::CNT_W-1:0]      rem;
  logic [zcfm_pkg::DIVIDEND_W-1:0] quo;
  logic [zcfm_pkg::STEP_W-1:0]     steps;

  logic                            full;
  logic [zcfm_pkg::SAMPLE_W-1:0]   mul_op;
  logic [zcfm_pkg::PROD_W-1:0]     prod;
  logic                            above;
  logic                            flip;
  logic [zcfm_pkg::CHG_W-1:0]      changes_next;
  logic [zcfm_pkg::CNT_W-1:0]      count_next;
  logic [zcfm_pkg::CNT_W:0]        trial;
  logic                            fit;

  assign full   = (fill == zcfm_pkg::FILL_W'(zcfm_pkg::DEPTH));
  assign mul_op = cmd.setup ? sample : rdata;
  assign prod   = zcfm_pkg::PROD_W'(mul_op) * zcfm_pkg::PROD_W'(fill);
  assign above  = prod > zcfm_pkg::PROD_W'(sum);

  assign flip         = (above != side);
  assign changes_next = changes + zcfm_pkg::CHG_W'(flip);
  assign count_next   = count + zcfm_pkg::CNT_W'(changes_next != '0);

  assign trial = {rem, quo[zcfm_pkg::DIVIDEND_W-1]};
  assign fit   = trial >= {1'b0, divisor};

  assign st.few      = fill < zcfm_pkg::MIN_FILL;
  assign st.found    = found;
  assign st.walk_end = (remain == '0) && !rd_pend;
  assign st.div_done = (steps == '0);
  assign st.out_busy = out_valid && !out_ready;

  // Sample store: one write, one registered read
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[wp] <= sample;
    end
    if (cmd.read_old) begin
      rdata <= mem[wp];
    end else if (cmd.walk && !found && remain != '0) begin
      rdata <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rate      <= zcfm_pkg::RATE_RESET;
      wp        <= '0;
      fill      <= '0;
      sum       <= '0;
      rd_pend   <= 1'b0;
      remain    <= '0;
      found     <= 1'b0;
      steps     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        rate <= sample_rate_hz;
      end
      if (cmd.accept) begin
        sample <= adc_sample;
      end
      // Drop the oldest sample from the sum once the ring is full
      if (cmd.push) begin
        if (full) begin
          sum <= sum - zcfm_pkg::SUM_W'(rdata) + zcfm_pkg::SUM_W'(sample);
        end else begin
          sum  <= sum + zcfm_pkg::SUM_W'(sample);
          fill <= fill + 1'b1;
        end
        wp <= wp + 1'b1;
      end
      if (cmd.setup) begin
        side    <= above;
        changes <= '0;
        count   <= '0;
        found   <= 1'b0;
        rd_pend <= 1'b0;
        addr    <= wp - zcfm_pkg::PTR_W'(2);
        remain  <= fill - zcfm_pkg::FILL_W'(2);
      end
      if (cmd.walk && !found) begin
        rd_pend <= (remain != '0);
        if (remain != '0) begin
          addr   <= addr - 1'b1;
          remain <= remain - 1'b1;
        end
        if (rd_pend) begin
          changes <= changes_next;
          count   <= count_next;
          if (flip) begin
            side <= above;
          end
          if (changes_next == zcfm_pkg::CROSSINGS) begin
            found <= 1'b1;
          end
        end
      end
      // Restoring divide, one quotient bit a cycle
      if (cmd.div_start) begin
        quo     <= {rate, zcfm_pkg::FRAC_W'(0)};
        rem     <= '0;
        divisor <= count;
        steps   <= zcfm_pkg::STEP_W'(zcfm_pkg::DIVIDEND_W);
      end else if (cmd.div_run && steps != '0) begin
        rem   <= fit ? zcfm_pkg::CNT_W'(trial - {1'b0, divisor}) : trial[zcfm_pkg::CNT_W-1:0];
        quo   <= {quo[zcfm_pkg::DIVIDEND_W-2:0], fit};
        steps <= steps - 1'b1;
      end
      if (cmd.load_out) begin
        out_valid  <= 1'b1;
        freq_valid <= found;
        freq_q8_hz <= found ? quo[zcfm_pkg::FREQ_W-1:0] : '0;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
